// ===== sv/ism_pkg.sv =====
// shared types and constants for the ising metropolis site update block
package ism_pkg;

	localparam int DEF_ROWS  = 64;
	localparam int DEF_COLS  = 64;
	localparam int ROW_W     = 6;
	localparam int COL_W     = 6;
	localparam int RND_W     = 11;
	localparam int THR_W     = 12;
	localparam int THR_N     = 5;
	localparam int TBL_W     = THR_W * THR_N;
	localparam int MOM_W     = 14;
	localparam int BOND_W    = 16;
	localparam int CFG_IDX_W = 1;

	localparam logic FUNC_STEP  = 1'b0;
	localparam logic FUNC_WRITE = 1'b1;

	localparam logic [CFG_IDX_W-1:0] REG_ACCEPT_UP   = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ACCEPT_DOWN = 1'd1;

	typedef enum logic [1:0] {
		S_CLEAR,
		S_IDLE,
		S_READ,
		S_EXEC
	} state_t;

	// site spin and its four neighbours, 1 = +1
	typedef struct packed {
		logic s;
		logic up;
		logic dn;
		logic lf;
		logic rt;
	} nbr_t;

	typedef struct packed {
		logic                     flip;
		logic                     flipped;
		logic                     spin_new;
		logic signed [MOM_W-1:0]  moment_next;
		logic signed [BOND_W-1:0] bond_next;
	} dec_t;

endpackage

// ===== sv/ism_lattice_mem.sv =====
// lattice row store: one write port, two read ports with registered read data
module ism_lattice_mem #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re0,
	input  logic [$clog2(DEPTH)-1:0] raddr0,
	output logic [WIDTH-1:0]         rdata0,
	input  logic                     re1,
	input  logic [$clog2(DEPTH)-1:0] raddr1,
	output logic [WIDTH-1:0]         rdata1
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re0) begin
			rdata0 <= mem[raddr0];
		end
		if (re1) begin
			rdata1 <= mem[raddr1];
		end
	end

endmodule

// ===== sv/ism_flip_calc.sv =====
// flip decision from the acceptance tables and update of the running totals
module ism_flip_calc (
	input  logic                           func,
	input  logic                           spin_value,
	input  logic [ism_pkg::RND_W-1:0]      random_fraction,
	input  logic [ism_pkg::TBL_W-1:0]      accept_spin_up,
	input  logic [ism_pkg::TBL_W-1:0]      accept_spin_down,
	input  ism_pkg::nbr_t                  nbr,
	input  logic signed [ism_pkg::MOM_W-1:0]  moment_cur,
	input  logic signed [ism_pkg::BOND_W-1:0] bond_cur,
	output ism_pkg::dec_t                  dec
);
	import ism_pkg::*;

	logic [TBL_W-1:0]      tbl;
	logic [THR_W-1:0]      thr_fld [THR_N];
	logic [2:0]            ones;
	logic [THR_W-1:0]      thr;
	logic signed [BOND_W-1:0] nsum;
	logic signed [BOND_W-1:0] bond_delta;

	assign tbl = nbr.s ? accept_spin_up : accept_spin_down;

	for (genvar k = 0; k < THR_N; k++) begin : g_fld
		assign thr_fld[k] = tbl[k*THR_W +: THR_W];
	end

	// table index (n+4)/2 is the count of up neighbours
	assign ones = 3'(nbr.up) + 3'(nbr.dn) + 3'(nbr.lf) + 3'(nbr.rt);
	assign thr  = thr_fld[ones];

	assign nsum       = BOND_W'({ones, 1'b0}) - BOND_W'(4);
	assign bond_delta = nsum <<< 2;

	always_comb begin
		dec = '0;
		if (func == FUNC_WRITE) begin
			dec.flip    = (nbr.s != spin_value);
			dec.flipped = 1'b0;
		end else begin
			dec.flip    = ({1'b0, random_fraction} < thr);
			dec.flipped = dec.flip;
		end
		dec.spin_new    = nbr.s ^ dec.flip;
		dec.moment_next = moment_cur;
		dec.bond_next   = bond_cur;
		if (dec.flip) begin
			if (nbr.s) begin
				dec.moment_next = moment_cur - MOM_W'(2);
				dec.bond_next   = bond_cur - bond_delta;
			end else begin
				dec.moment_next = moment_cur + MOM_W'(2);
				dec.bond_next   = bond_cur + bond_delta;
			end
		end
	end

endmodule

// ===== sv/ising_metropolis_site_update.sv =====
// top level of the ising metropolis site update block
// The lattice sits in a row-wide memory of ROWS words of COLS bits with one write port and
// two read ports. After reset a clearing pass writes every row to all spins up, during which
// no item is taken; configuration writes are taken at any time. Each item then passes S_IDLE,
// where the transfer reads the site's row and the row above, S_READ, which reads the row below,
// and S_EXEC, which, once the output register is free, decides the flip and writes the row back,
// as the two read ports of the row memory cannot fetch all three rows at once. A result waits in
// the output register while the next item is taken. The totals are kept modulo 2^14 and 2^16.
module ising_metropolis_site_update #(
	parameter int ROWS = ism_pkg::DEF_ROWS,
	parameter int COLS = ism_pkg::DEF_COLS
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [ism_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [ism_pkg::TBL_W-1:0]         cfg_data,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic                              func,
	input  logic [ism_pkg::ROW_W-1:0]         row,
	input  logic [ism_pkg::COL_W-1:0]         col,
	input  logic                              spin_value,
	input  logic [ism_pkg::RND_W-1:0]         random_fraction,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic                              flipped,
	output logic                              spin_now,
	output logic signed [ism_pkg::MOM_W-1:0]  moment,
	output logic signed [ism_pkg::BOND_W-1:0] bond_sum
);
	import ism_pkg::*;

	localparam int RW = $clog2(ROWS);
	localparam int CW = $clog2(COLS);

	// wrapped site and neighbour indexes, constant tables
	logic [RW-1:0] rmod_tab [2**ROW_W];
	logic [RW-1:0] rup_tab  [2**ROW_W];
	logic [RW-1:0] rdn_tab  [2**ROW_W];
	logic [CW-1:0] cmod_tab [2**COL_W];
	logic [CW-1:0] clf_tab  [2**COL_W];
	logic [CW-1:0] crt_tab  [2**COL_W];

	for (genvar i = 0; i < 2**ROW_W; i++) begin : g_rtab
		assign rmod_tab[i] = RW'(i % ROWS);
		assign rup_tab[i]  = RW'(((i % ROWS) + ROWS - 1) % ROWS);
		assign rdn_tab[i]  = RW'(((i % ROWS) + 1) % ROWS);
	end

	for (genvar j = 0; j < 2**COL_W; j++) begin : g_ctab
		assign cmod_tab[j] = CW'(j % COLS);
		assign clf_tab[j]  = CW'(((j % COLS) + COLS - 1) % COLS);
		assign crt_tab[j]  = CW'(((j % COLS) + 1) % COLS);
	end

	state_t state_q, state_d;

	logic [TBL_W-1:0] accept_spin_up_q;
	logic [TBL_W-1:0] accept_spin_down_q;

	logic [RW-1:0]    clr_cnt_q;
	logic             func_q;
	logic             spin_value_q;
	logic [RND_W-1:0] rnd_q;
	logic [RW-1:0]    rm_q;
	logic [RW-1:0]    dn_q;
	logic [CW-1:0]    cm_q;
	logic [CW-1:0]    lf_q;
	logic [CW-1:0]    rt_q;
	logic             up_bit_q;

	logic                     out_valid_q;
	logic                     flipped_q;
	logic                     spin_now_q;
	logic signed [MOM_W-1:0]  moment_q;
	logic signed [BOND_W-1:0] bond_q;

	logic             mem_we;
	logic [RW-1:0]    mem_waddr;
	logic [COLS-1:0]  mem_wdata;
	logic             mem_re0;
	logic [RW-1:0]    mem_raddr0;
	logic [COLS-1:0]  mem_rdata0;
	logic             mem_re1;
	logic [RW-1:0]    mem_raddr1;
	logic [COLS-1:0]  mem_rdata1;

	logic  in_xfer;
	logic  clr_inc;
	logic  commit;
	logic  slot_free;
	nbr_t  nbr;
	dec_t  dec;

	ism_lattice_mem #(
		.DEPTH(ROWS),
		.WIDTH(COLS)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re0   (mem_re0),
		.raddr0(mem_raddr0),
		.rdata0(mem_rdata0),
		.re1   (mem_re1),
		.raddr1(mem_raddr1),
		.rdata1(mem_rdata1)
	);

	assign nbr.s  = mem_rdata0[cm_q];
	assign nbr.lf = mem_rdata0[lf_q];
	assign nbr.rt = mem_rdata0[rt_q];
	assign nbr.up = up_bit_q;
	assign nbr.dn = mem_rdata1[cm_q];

	ism_flip_calc u_calc (
		.func            (func_q),
		.spin_value      (spin_value_q),
		.random_fraction (rnd_q),
		.accept_spin_up  (accept_spin_up_q),
		.accept_spin_down(accept_spin_down_q),
		.nbr             (nbr),
		.moment_cur      (moment_q),
		.bond_cur        (bond_q),
		.dec             (dec)
	);

	assign slot_free = !out_valid_q || out_ready;

	always_comb begin
		state_d    = state_q;
		in_ready   = 1'b0;
		in_xfer    = 1'b0;
		clr_inc    = 1'b0;
		commit     = 1'b0;
		mem_we     = 1'b0;
		mem_waddr  = rm_q;
		mem_wdata  = mem_rdata0;
		mem_re0    = 1'b0;
		mem_raddr0 = rmod_tab[row];
		mem_re1    = 1'b0;
		mem_raddr1 = rup_tab[row];
		case (state_q)
			S_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_cnt_q;
				mem_wdata = '1;
				clr_inc   = 1'b1;
				if (clr_cnt_q == RW'(ROWS - 1)) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					in_xfer = 1'b1;
					mem_re0 = 1'b1;
					mem_re1 = 1'b1;
					state_d = S_READ;
				end
			end
			S_READ: begin
				mem_re1    = 1'b1;
				mem_raddr1 = dn_q;
				state_d    = S_EXEC;
			end
			S_EXEC: begin
				if (slot_free) begin
					commit             = 1'b1;
					mem_we             = 1'b1;
					mem_wdata[cm_q]    = dec.spin_new;
					state_d            = S_IDLE;
				end
			end
			default: begin
				state_d = S_CLEAR;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_CLEAR;
			clr_cnt_q <= '0;
		end else begin
			state_q <= state_d;
			if (clr_inc) begin
				clr_cnt_q <= clr_cnt_q + RW'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			accept_spin_up_q   <= '0;
			accept_spin_down_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ACCEPT_UP:   accept_spin_up_q   <= cfg_data;
				REG_ACCEPT_DOWN: accept_spin_down_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// request capture
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			func_q       <= func;
			spin_value_q <= spin_value;
			rnd_q        <= random_fraction;
			rm_q         <= rmod_tab[row];
			dn_q         <= rdn_tab[row];
			cm_q         <= cmod_tab[col];
			lf_q         <= clf_tab[col];
			rt_q         <= crt_tab[col];
		end
		if (state_q == S_READ) begin
			up_bit_q <= mem_rdata1[cm_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			moment_q    <= MOM_W'(ROWS * COLS);
			bond_q      <= BOND_W'(4 * ROWS * COLS);
		end else begin
			if (commit) begin
				out_valid_q <= 1'b1;
				moment_q    <= dec.moment_next;
				bond_q      <= dec.bond_next;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			flipped_q  <= dec.flipped;
			spin_now_q <= dec.spin_new;
		end
	end

	assign out_valid = out_valid_q;
	assign flipped   = flipped_q;
	assign spin_now  = spin_now_q;
	assign moment    = moment_q;
	assign bond_sum  = bond_q;

endmodule

// ===== sim/tb.sv =====
// testbench for the ising metropolis site update block: lattice scoreboard, stimulus and checks
`timescale 1ns / 1ps

module tb;
	import ism_pkg::*;

	localparam int LAT_ROWS    = DEF_ROWS;
	localparam int LAT_COLS    = DEF_COLS;
	localparam int PHASES      = 7;
	localparam int PHASE_ITEMS = 100;
	localparam int HOLD_CYCLES = 300;
	localparam int RUN_LIMIT   = 400000;
	localparam int REPORT_MAX  = 40;

	typedef struct {
		logic                     flipped;
		logic                     spin_now;
		logic signed [MOM_W-1:0]  moment;
		logic signed [BOND_W-1:0] bond_sum;
	} site_result_t;

	class lattice_scoreboard;
		bit                       spins [LAT_ROWS][LAT_COLS];
		logic signed [MOM_W-1:0]  magnet;
		logic signed [BOND_W-1:0] bond_total;
		logic [TBL_W-1:0]         thr_up;
		logic [TBL_W-1:0]         thr_down;
		site_result_t             awaited_results[$];
		int                       errors;
		int                       checked;

		function new();
			foreach (spins[r, c]) spins[r][c] = 1'b1;
			magnet     = MOM_W'(LAT_ROWS * LAT_COLS);
			bond_total = BOND_W'(4 * LAT_ROWS * LAT_COLS);
			thr_up     = '0;
			thr_down   = '0;
			errors     = 0;
			checked    = 0;
		endfunction

		function void report(string what);
			errors++;
			if (errors <= REPORT_MAX)
				$display("[%0t] mismatch: %s", $realtime, what);
		endfunction

		function void set_table(logic [CFG_IDX_W-1:0] idx, logic [TBL_W-1:0] val);
			if (idx == REG_ACCEPT_UP)
				thr_up = val;
			else if (idx == REG_ACCEPT_DOWN)
				thr_down = val;
		endfunction

		function int spin_of(int r, int c);
			return spins[(r + LAT_ROWS) % LAT_ROWS][(c + LAT_COLS) % LAT_COLS] ? 1 : -1;
		endfunction

		function void note_site_op(logic f, logic [ROW_W-1:0] r_in, logic [COL_W-1:0] c_in,
			logic sv, logic [RND_W-1:0] rnd);
			int               r;
			int               c;
			int               s;
			int               n;
			int               k;
			logic [TBL_W-1:0] tbl;
			logic [THR_W-1:0] thr;
			bit               change;
			site_result_t     res;
			r = r_in % LAT_ROWS;
			c = c_in % LAT_COLS;
			s = spin_of(r, c);
			n = spin_of(r - 1, c) + spin_of(r + 1, c) + spin_of(r, c - 1) + spin_of(r, c + 1);
			change = 1'b0;
			res.flipped = 1'b0;
			if (f == FUNC_WRITE) begin
				change = (spins[r][c] != sv);
			end else begin
				tbl = spins[r][c] ? thr_up : thr_down;
				k   = (n + 4) / 2;
				thr = tbl[k*THR_W +: THR_W];
				if (rnd < thr) begin
					change      = 1'b1;
					res.flipped = 1'b1;
				end
			end
			if (change) begin
				spins[r][c] = ~spins[r][c];
				magnet      = MOM_W'(magnet - 2 * s);
				bond_total  = BOND_W'(bond_total - 4 * s * n);
			end
			res.spin_now = spins[r][c];
			res.moment   = magnet;
			res.bond_sum = bond_total;
			awaited_results.push_back(res);
		endfunction

		function void check_site_result(logic fl, logic sn, logic signed [MOM_W-1:0] m,
			logic signed [BOND_W-1:0] b);
			site_result_t e;
			if (awaited_results.size() == 0) begin
				report("result transfer with no site operation pending");
				return;
			end
			e = awaited_results.pop_front();
			checked++;
			if (fl !== e.flipped)
				report($sformatf("result %0d flipped: got %b, want %b", checked, fl, e.flipped));
			if (sn !== e.spin_now)
				report($sformatf("result %0d spin_now: got %b, want %b", checked, sn, e.spin_now));
			if (m !== e.moment)
				report($sformatf("result %0d moment: got %0d, want %0d", checked, m, e.moment));
			if (b !== e.bond_sum)
				report($sformatf("result %0d bond_sum: got %0d, want %0d", checked, b, e.bond_sum));
		endfunction
	endclass

	logic                      clk;
	logic                      arst_n;
	logic                      cfg_we;
	logic [CFG_IDX_W-1:0]      cfg_index;
	logic [TBL_W-1:0]          cfg_data;
	logic                      in_valid;
	logic                      in_ready;
	logic                      func;
	logic [ROW_W-1:0]          row;
	logic [COL_W-1:0]          col;
	logic                      spin_value;
	logic [RND_W-1:0]          random_fraction;
	logic                      out_valid;
	logic                      out_ready;
	logic                      flipped;
	logic                      spin_now;
	logic signed [MOM_W-1:0]   moment;
	logic signed [BOND_W-1:0]  bond_sum;

	lattice_scoreboard sb;
	int                sink_mode;
	bit                hold_req;
	logic [ROW_W-1:0]  win_row;
	logic [COL_W-1:0]  win_col;
	logic [ROW_W-1:0]  last_row;
	logic [COL_W-1:0]  last_col;
	int                cycles;

	ising_metropolis_site_update uut (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.func            (func),
		.row             (row),
		.col             (col),
		.spin_value      (spin_value),
		.random_fraction (random_fraction),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.flipped         (flipped),
		.spin_now        (spin_now),
		.moment          (moment),
		.bond_sum        (bond_sum)
	);

	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	always @(posedge clk) begin
		if (arst_n && sb != null) begin
			if (out_valid && out_ready)
				sb.check_site_result(flipped, spin_now, moment, bond_sum);
			if (in_valid && in_ready)
				sb.note_site_op(func, row, col, spin_value, random_fraction);
		end
	end

	initial begin
		cycles = 0;
		while (cycles < RUN_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("== FAIL ==");
		$finish;
	end

	// receiver: stall pattern per mode, or one long hold-off on request
	initial begin
		int held;
		int beat;
		out_ready = 1'b0;
		beat = 0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				out_ready <= 1'b0;
				held = 0;
				while (held < HOLD_CYCLES) begin
					@(negedge clk);
					held++;
				end
				hold_req = 1'b0;
			end else begin
				beat++;
				case (sink_mode)
					0: out_ready <= 1'b1;
					1: out_ready <= ($urandom_range(0, 3) != 0);
					2: out_ready <= ((beat % 7) < 4);
					default: out_ready <= ($urandom_range(0, 3) == 0);
				endcase
			end
		end
	end

	task automatic push_site(input logic f, input logic [ROW_W-1:0] r, input logic [COL_W-1:0] c,
		input logic sv, input logic [RND_W-1:0] rnd);
		in_valid        <= 1'b1;
		func            <= f;
		row             <= r;
		col             <= c;
		spin_value      <= sv;
		random_fraction <= rnd;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic idle_gap(input int n);
		in_valid <= 1'b0;
		repeat (n) @(negedge clk);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (sb.awaited_results.size() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_tables(input logic [TBL_W-1:0] up_t, input logic [TBL_W-1:0] dn_t);
		cfg_we    <= 1'b1;
		cfg_index <= REG_ACCEPT_UP;
		cfg_data  <= up_t;
		@(negedge clk);
		cfg_index <= REG_ACCEPT_DOWN;
		cfg_data  <= dn_t;
		@(negedge clk);
		cfg_we    <= 1'b0;
		sb.set_table(REG_ACCEPT_UP, up_t);
		sb.set_table(REG_ACCEPT_DOWN, dn_t);
		@(negedge clk);
	endtask

	function automatic logic [TBL_W-1:0] random_thresholds();
		logic [TBL_W-1:0] t;
		logic [THR_W-1:0] v;
		for (int k = 0; k < THR_N; k++) begin
			case ($urandom_range(0, 4))
				0: v = '0;
				1: v = 12'd2048;
				2: v = '1;
				3: v = THR_W'($urandom_range(0, 2047));
				default: v = THR_W'($urandom_range(1, 4095));
			endcase
			t[k*THR_W +: THR_W] = v;
		end
		return t;
	endfunction

	// most sites cluster in a small window or next to the previous one so neighbours interact
	task automatic send_random_site();
		logic             f;
		logic             sv;
		logic [ROW_W-1:0] r;
		logic [COL_W-1:0] c;
		logic [RND_W-1:0] rnd;
		int               pick;
		pick = $urandom_range(0, 9);
		if (pick < 4) begin
			r = ROW_W'(win_row + $urandom_range(0, 4));
			c = COL_W'(win_col + $urandom_range(0, 4));
		end else if (pick < 7) begin
			r = last_row;
			c = last_col;
			case ($urandom_range(0, 3))
				0: r = ROW_W'(last_row + 1);
				1: r = ROW_W'(last_row - 1);
				2: c = COL_W'(last_col + 1);
				default: c = COL_W'(last_col - 1);
			endcase
		end else begin
			r = ROW_W'($urandom);
			c = COL_W'($urandom);
		end
		f  = ($urandom_range(0, 3) == 0) ? FUNC_WRITE : FUNC_STEP;
		sv = 1'($urandom);
		case ($urandom_range(0, 9))
			0: rnd = '0;
			1: rnd = '1;
			default: rnd = RND_W'($urandom);
		endcase
		push_site(f, r, c, sv, rnd);
		last_row = r;
		last_col = c;
	endtask

	initial begin
		logic [TBL_W-1:0] up_t;
		logic [TBL_W-1:0] dn_t;
		int               left;
		int               burst;
		bit               gappy;
		sb              = new();
		arst_n          = 1'b0;
		cfg_we          = 1'b0;
		cfg_index       = REG_ACCEPT_UP;
		cfg_data        = '0;
		in_valid        = 1'b0;
		func            = FUNC_STEP;
		row             = '0;
		col             = '0;
		spin_value      = 1'b0;
		random_fraction = '0;
		sink_mode       = 1;
		hold_req        = 1'b0;
		win_row         = '0;
		win_col         = '0;
		last_row        = '0;
		last_col        = '0;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;

		// tables still at reset: zero threshold never flips
		push_site(FUNC_STEP, 6'd0, 6'd0, 1'b1, 11'd0);
		push_site(FUNC_WRITE, 6'd0, 6'd0, 1'b0, 11'd2047);
		push_site(FUNC_WRITE, 6'd0, 6'd0, 1'b0, 11'd0);
		push_site(FUNC_WRITE, 6'd63, 6'd63, 1'b1, 11'd0);
		push_site(FUNC_WRITE, 6'd63, 6'd0, 1'b0, 11'd0);
		push_site(FUNC_WRITE, 6'd1, 6'd0, 1'b0, 11'd0);
		push_site(FUNC_WRITE, 6'd0, 6'd63, 1'b0, 11'd0);
		push_site(FUNC_WRITE, 6'd0, 6'd1, 1'b0, 11'd0);
		push_site(FUNC_WRITE, 6'd0, 6'd0, 1'b1, 11'd0);
		drain();

		// up: 2048, 0, 1, 2047, 4095 by neighbour sum; down: 0, 4095, 2048, 1, 2047
		write_tables({12'd4095, 12'd2047, 12'd1, 12'd0, 12'd2048},
			{12'd2047, 12'd1, 12'd2048, 12'd4095, 12'd0});
		push_site(FUNC_STEP, 6'd0, 6'd0, 1'b0, 11'd2047);
		push_site(FUNC_STEP, 6'd0, 6'd0, 1'b1, 11'd2047);
		push_site(FUNC_STEP, 6'd32, 6'd32, 1'b0, 11'd0);
		push_site(FUNC_STEP, 6'd32, 6'd32, 1'b1, 11'd2047);
		push_site(FUNC_STEP, 6'd32, 6'd32, 1'b0, 11'd2046);
		push_site(FUNC_WRITE, 6'd20, 6'd21, 1'b0, 11'd0);
		push_site(FUNC_STEP, 6'd20, 6'd20, 1'b1, 11'd1);
		push_site(FUNC_STEP, 6'd20, 6'd20, 1'b1, 11'd0);
		push_site(FUNC_STEP, 6'd63, 6'd63, 1'b0, 11'd1365);
		push_site(FUNC_WRITE, 6'd42, 6'd21, 1'b1, 11'd682);

		for (int ph = 0; ph < PHASES; ph++) begin
			drain();
			case (ph)
				1: begin
					up_t = '1;
					dn_t = '0;
				end
				2: begin
					up_t = '0;
					dn_t = '1;
				end
				default: begin
					up_t = random_thresholds();
					dn_t = random_thresholds();
				end
			endcase
			write_tables(up_t, dn_t);
			win_row   = ROW_W'($urandom);
			win_col   = COL_W'($urandom);
			sink_mode = ph % 4;
			gappy     = (ph != 2) && (ph != 5);
			if (ph == 2)
				hold_req = 1'b1;
			left = PHASE_ITEMS;
			while (left > 0) begin
				burst = $urandom_range(1, 24);
				while (burst > 0 && left > 0) begin
					send_random_site();
					burst--;
					left--;
					if (ph == 4 && left == PHASE_ITEMS / 2)
						drain();
				end
				if (gappy && left > 0)
					idle_gap($urandom_range(1, 6));
			end
		end

		drain();
		repeat (10) @(negedge clk);
		if (sb.errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
